/* design/crp_pkg.sv */
// Shared types, constants and helper functions of the radar measurement block.
// No dependencies; every other file of the block but crp_if refers to this package.
package crp_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 34;
  localparam int FIFO_DEPTH   = 4;
  // Back-end stage at which the dot product and the range meet the divider.
  localparam int DIV_T        = 38;
  // Stage index of the output register, counted from the queue head.
  localparam int LAT          = DIV_T + DIV_STEPS + 2;

  localparam int CFG_AW = 3;
  localparam logic REG_MIN_RANGE = 1'b0;

  localparam logic signed [33:0] ANG_PI      = 34'sd843314857;
  localparam logic signed [33:0] ANG_HALF_PI = 34'sd421657428;
  localparam logic signed [33:0] ANG_TWO_PI  = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [31:0] ANG_MAX     = 32'sd843314857;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] speed;
    logic signed [31:0] head;
    logic               flip;
    logic signed [32:0] vec_x;
    logic signed [32:0] vec_y;
    logic signed [31:0] vec_z;
  } q_entry_t;

  // Arctangent of 2^-i in Q3.28.
  function automatic logic signed [31:0] atan_q28(int unsigned i);
    logic signed [31:0] v;
    case (i)
      0: v = 32'sd210828714;
      1: v = 32'sd124459457;
      2: v = 32'sd65760959;
      3: v = 32'sd33381290;
      4: v = 32'sd16755422;
      5: v = 32'sd8385879;
      6: v = 32'sd4193963;
      7: v = 32'sd2097109;
      8: v = 32'sd1048571;
      9: v = 32'sd524287;
      default: v = (i <= 28) ? (32'sd1 <<< (28 - i)) : 32'sd0;
    endcase
    return v;
  endfunction

endpackage

/* design/crp_if.sv */
// Stream channel interfaces of the radar measurement block: input items and results.
// Depends on nothing; the top level and its submodules use the modports.
interface crp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] speed;
  logic signed [31:0] heading;
  modport source (output valid, pos_x, pos_y, speed, heading, input ready);
  modport sink (input valid, pos_x, pos_y, speed, heading, output ready);
endinterface

interface crp_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] range;
  logic signed [30:0] bearing;
  logic signed [31:0] range_rate;
  logic               at_origin;
  modport source (output valid, range, bearing, range_rate, at_origin, input ready);
  modport sink (input valid, range, bearing, range_rate, at_origin, output ready);
endinterface

/* design/crp_front.sv */
// Front end: accepts input beats, wraps and folds the heading, sets up the vectoring start.
// Depends on crp_pkg and crp_in_if; writes into the queue.
module crp_front (
  crp_in_if.sink           in_i,
  input  logic             full_i,
  output logic             push_o,
  output crp_pkg::q_entry_t entry_o
);

  logic signed [33:0] h_w;
  logic signed [33:0] h_f;
  logic               flip;
  logic signed [32:0] px;
  logic signed [32:0] py;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    h_w = $signed({{2{in_i.heading[31]}}, in_i.heading});
    if (h_w > crp_pkg::ANG_PI) begin
      h_w = h_w - crp_pkg::ANG_TWO_PI;
    end else if (h_w < -crp_pkg::ANG_PI) begin
      h_w = h_w + crp_pkg::ANG_TWO_PI;
    end
    flip = 1'b0;
    h_f  = h_w;
    if (h_w > crp_pkg::ANG_HALF_PI) begin
      h_f  = h_w - crp_pkg::ANG_PI;
      flip = 1'b1;
    end else if (h_w < -crp_pkg::ANG_HALF_PI) begin
      h_f  = h_w + crp_pkg::ANG_PI;
      flip = 1'b1;
    end
  end

  always_comb begin
    px = $signed({in_i.pos_x[31], in_i.pos_x});
    py = $signed({in_i.pos_y[31], in_i.pos_y});
    entry_o.pos_x = in_i.pos_x;
    entry_o.pos_y = in_i.pos_y;
    entry_o.speed = in_i.speed;
    entry_o.head  = h_f[31:0];
    entry_o.flip  = flip;
    // Points in the left half plane get a quarter turn first.
    if (px[32]) begin
      if (!py[32]) begin
        entry_o.vec_x = py;
        entry_o.vec_y = -px;
        entry_o.vec_z = crp_pkg::ANG_HALF_PI[31:0];
      end else begin
        entry_o.vec_x = -py;
        entry_o.vec_y = px;
        entry_o.vec_z = -$signed(crp_pkg::ANG_HALF_PI[31:0]);
      end
    end else begin
      entry_o.vec_x = px;
      entry_o.vec_y = py;
      entry_o.vec_z = '0;
    end
  end

endmodule

/* design/crp_fifo.sv */
// Short queue that decouples the front end from the arithmetic back end.
// Depends on crp_pkg for the entry type and depth.
module crp_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  crp_pkg::q_entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output crp_pkg::q_entry_t head_o,
  output logic              empty_o
);

  localparam int PW = $clog2(crp_pkg::FIFO_DEPTH);

  crp_pkg::q_entry_t mem_q [crp_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [PW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PW+1)'(crp_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + PW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

/* design/crp_back.sv */
// Back end: pipelined CORDICs, square root, products and divider, all stages advancing together.
// Depends on crp_pkg and crp_out_if; takes entries from the queue head.
module crp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [15:0]       min_range_i,
  input  logic              empty_i,
  input  crp_pkg::q_entry_t head_i,
  output logic              pop_o,
  crp_out_if.source         out_o
);

  localparam int S       = crp_pkg::CORDIC_STEPS;
  localparam int L       = crp_pkg::LAT;
  localparam int NSQ     = crp_pkg::SQRT_STEPS;
  localparam int NDV     = crp_pkg::DIV_STEPS;
  localparam int DOT_DLY = crp_pkg::DIV_T - S - 5;
  localparam int RNG_DLY = crp_pkg::DIV_T - NSQ - 2;
  localparam int BRG_DLY = L - 2 - S;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [31:0] h;
    logic               flip;
  } rot_t;

  typedef struct packed {
    logic signed [65:0] x;
    logic signed [65:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] src;
  } sq_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [33:0] lo;
    logic [31:0] d;
    logic [33:0] q;
    logic        neg;
    logic        ovf;
    logic        org;
  } dv_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
  } pos_t;

  function automatic rot_t rot_step(rot_t a, int unsigned n);
    rot_t r;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    xs = $signed(a.x) >>> n;
    ys = $signed(a.y) >>> n;
    r  = a;
    if (!a.h[31]) begin
      r.x = $signed(a.x) - ys;
      r.y = $signed(a.y) + xs;
      r.h = $signed(a.h) - crp_pkg::atan_q28(n);
    end else begin
      r.x = $signed(a.x) + ys;
      r.y = $signed(a.y) - xs;
      r.h = $signed(a.h) + crp_pkg::atan_q28(n);
    end
    return r;
  endfunction

  function automatic vec_t vec_step(vec_t a, int unsigned n);
    vec_t r;
    logic signed [65:0] xs;
    logic signed [65:0] ys;
    xs = $signed(a.x) >>> n;
    ys = $signed(a.y) >>> n;
    if (!a.y[65] && (a.y != '0)) begin
      r.x = $signed(a.x) + ys;
      r.y = $signed(a.y) - xs;
      r.z = $signed(a.z) + crp_pkg::atan_q28(n);
    end else begin
      r.x = $signed(a.x) - ys;
      r.y = $signed(a.y) + xs;
      r.z = $signed(a.z) - crp_pkg::atan_q28(n);
    end
    return r;
  endfunction

  function automatic sq_t sq_step(sq_t a);
    sq_t r;
    logic [35:0] r2;
    logic [35:0] tr;
    r2 = {a.rem, a.src[63:62]};
    tr = {2'b00, a.root, 2'b01};
    if (r2 >= tr) begin
      r.rem  = 34'(r2 - tr);
      r.root = {a.root[30:0], 1'b1};
    end else begin
      r.rem  = r2[33:0];
      r.root = {a.root[30:0], 1'b0};
    end
    r.src = {a.src[61:0], 2'b00};
    return r;
  endfunction

  function automatic dv_t dv_step(dv_t a);
    dv_t r;
    logic [32:0] r2;
    r2 = {a.rem, a.lo[33]};
    r  = a;
    if (r2 >= {1'b0, a.d}) begin
      r.rem = 32'(r2 - {1'b0, a.d});
      r.q   = {a.q[32:0], 1'b1};
    end else begin
      r.rem = r2[31:0];
      r.q   = {a.q[32:0], 1'b0};
    end
    r.lo = {a.lo[32:0], 1'b0};
    return r;
  endfunction

  logic          en;
  logic [L:1]    vld_q;

  rot_t rot_q [1:S];
  rot_t rot_d [1:S];
  vec_t vec_q [1:S];
  vec_t vec_d [1:S];
  sq_t  sq_q  [1:NSQ];
  sq_t  sq_d  [1:NSQ];
  dv_t  dv_q  [1:NDV];
  dv_t  dv_d  [1:NDV];
  dv_t  dp_q, dp_d;

  pos_t               pos_q [1:S+3];
  logic signed [31:0] spd_q [1:S+1];
  logic        [63:0] sqx_q, sqy_q, sum_q;
  logic signed [31:0] c_q, s_q, c_d, s_d;
  logic signed [63:0] pc_q, ps_q, pc_d, ps_d;
  logic signed [31:0] vx_q, vy_q, vx_d, vy_d;
  logic signed [63:0] mx_q, my_q, mx_d, my_d;
  logic signed [63:0] dot_q;
  logic signed [63:0] dd_q [1:DOT_DLY];
  logic        [31:0] rd_q [1:RNG_DLY];
  logic signed [30:0] brg_q, brg_d;
  logic signed [30:0] bd_q [1:BRG_DLY];
  logic signed [63:0] sqx_d, sqy_d;

  logic        [31:0] range_q, range_d;
  logic signed [30:0] bearing_q, bearing_d;
  logic signed [31:0] rr_q, rr_d;
  logic               org_q, org_d;

  assign en    = !vld_q[L] || out_o.ready;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-1:1], pop_o};
    end
  end

  // CORDIC chains, square root and divider stages.
  always_comb begin
    rot_t r0;
    vec_t v0;
    r0.x    = crp_pkg::CORDIC_K;
    r0.y    = '0;
    r0.h    = head_i.head;
    r0.flip = head_i.flip;
    rot_d[1] = rot_step(r0, 0);
    for (int i = 2; i <= S; i++) begin
      rot_d[i] = rot_step(rot_q[i-1], (i - 1));
    end
    v0.x = $signed({{3{head_i.vec_x[32]}}, head_i.vec_x, 30'b0});
    v0.y = $signed({{3{head_i.vec_y[32]}}, head_i.vec_y, 30'b0});
    v0.z = head_i.vec_z;
    vec_d[1] = vec_step(v0, 0);
    for (int i = 2; i <= S; i++) begin
      vec_d[i] = vec_step(vec_q[i-1], (i - 1));
    end
    sq_d[1] = sq_step('{rem: '0, root: '0, src: sum_q});
    for (int k = 2; k <= NSQ; k++) begin
      sq_d[k] = sq_step(sq_q[k-1]);
    end
    dv_d[1] = dv_step(dp_q);
    for (int k = 2; k <= NDV; k++) begin
      dv_d[k] = dv_step(dv_q[k-1]);
    end
  end

  // Squares, velocity and dot product.
  always_comb begin
    logic signed [33:0] xf;
    logic signed [33:0] yf;
    logic signed [63:0] tx;
    logic signed [63:0] ty;
    sqx_d = $signed(head_i.pos_x) * $signed(head_i.pos_x);
    sqy_d = $signed(head_i.pos_y) * $signed(head_i.pos_y);
    xf = rot_q[S].flip ? -$signed(rot_q[S].x) : $signed(rot_q[S].x);
    yf = rot_q[S].flip ? -$signed(rot_q[S].y) : $signed(rot_q[S].y);
    if (xf > crp_pkg::ONE_Q30) xf = crp_pkg::ONE_Q30;
    else if (xf < -crp_pkg::ONE_Q30) xf = -crp_pkg::ONE_Q30;
    if (yf > crp_pkg::ONE_Q30) yf = crp_pkg::ONE_Q30;
    else if (yf < -crp_pkg::ONE_Q30) yf = -crp_pkg::ONE_Q30;
    c_d  = xf[31:0];
    s_d  = yf[31:0];
    pc_d = $signed(spd_q[S+1]) * $signed(c_q);
    ps_d = $signed(spd_q[S+1]) * $signed(s_q);
    tx   = pc_q >>> 30;
    ty   = ps_q >>> 30;
    if (tx > 64'sd2147483647) tx = 64'sd2147483647;
    else if (tx < -64'sd2147483647) tx = -64'sd2147483647;
    if (ty > 64'sd2147483647) ty = 64'sd2147483647;
    else if (ty < -64'sd2147483647) ty = -64'sd2147483647;
    vx_d = tx[31:0];
    vy_d = ty[31:0];
    mx_d = $signed(pos_q[S+3].px) * $signed(vx_q);
    my_d = $signed(pos_q[S+3].py) * $signed(vy_q);
  end

  // Bearing clamp, divider setup and result formation.
  always_comb begin
    logic signed [31:0] z;
    logic signed [63:0] dv;
    logic        [63:0] mag;
    logic        [31:0] rng;
    z = vec_q[S].z;
    if (z > crp_pkg::ANG_MAX) z = crp_pkg::ANG_MAX;
    else if (z < -crp_pkg::ANG_MAX) z = -crp_pkg::ANG_MAX;
    brg_d = z[30:0];

    dv  = dd_q[DOT_DLY];
    rng = rd_q[RNG_DLY];
    mag = dv[63] ? 64'(-dv) : 64'(dv);
    dp_d.neg = dv[63];
    dp_d.rem = {2'b00, mag[63:34]};
    dp_d.lo  = mag[33:0];
    dp_d.d   = rng;
    dp_d.q   = '0;
    dp_d.ovf = ({2'b00, mag[63:34]} >= rng);
    dp_d.org = (rng == '0) || (rng < {16'b0, min_range_i});

    if (dv_q[NDV].ovf) begin
      rr_d = dv_q[NDV].neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (!dv_q[NDV].neg) begin
      rr_d = (dv_q[NDV].q > 34'h0_7fff_ffff) ? 32'sh7fff_ffff : dv_q[NDV].q[31:0];
    end else begin
      rr_d = (dv_q[NDV].q > 34'h0_8000_0000) ? 32'sh8000_0000 : 32'(-dv_q[NDV].q);
    end
    range_d   = dv_q[NDV].d;
    bearing_d = bd_q[BRG_DLY];
    org_d     = dv_q[NDV].org;
    if (dv_q[NDV].org) begin
      range_d   = '0;
      bearing_d = '0;
      rr_d      = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rot_q <= rot_d;
      vec_q <= vec_d;
      sq_q  <= sq_d;
      dv_q  <= dv_d;
      dp_q  <= dp_d;
      pos_q[1] <= '{px: head_i.pos_x, py: head_i.pos_y};
      for (int k = 2; k <= S + 3; k++) pos_q[k] <= pos_q[k-1];
      spd_q[1] <= head_i.speed;
      for (int k = 2; k <= S + 1; k++) spd_q[k] <= spd_q[k-1];
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      sum_q <= sqx_q + sqy_q;
      c_q   <= c_d;
      s_q   <= s_d;
      pc_q  <= pc_d;
      ps_q  <= ps_d;
      vx_q  <= vx_d;
      vy_q  <= vy_d;
      mx_q  <= mx_d;
      my_q  <= my_d;
      dot_q <= mx_q + my_q;
      dd_q[1] <= dot_q;
      for (int k = 2; k <= DOT_DLY; k++) dd_q[k] <= dd_q[k-1];
      rd_q[1] <= sq_q[NSQ].root;
      for (int k = 2; k <= RNG_DLY; k++) rd_q[k] <= rd_q[k-1];
      brg_q <= brg_d;
      bd_q[1] <= brg_q;
      for (int k = 2; k <= BRG_DLY; k++) bd_q[k] <= bd_q[k-1];
      range_q   <= range_d;
      bearing_q <= bearing_d;
      rr_q      <= rr_d;
      org_q     <= org_d;
    end
  end

  assign out_o.valid      = vld_q[L];
  assign out_o.range      = range_q;
  assign out_o.bearing    = bearing_q;
  assign out_o.range_rate = rr_q;
  assign out_o.at_origin  = org_q;

endmodule

/* design/cartesian_to_radar_polar.sv */
// Top level of the radar measurement block: range, bearing and range rate of a point.
// Depends on crp_pkg, crp_if, crp_front, crp_fifo and crp_back.
//
// Throughput: one beat per cycle while results are taken; every unit is fully pipelined,
// the longest chain being square root, divider setup and the 34-step quotient pipeline
// behind the dot product.
// Reset (rst_ni low, asynchronous): queue and stage valid bits clear, min_range returns
// to 1; no memory needs clearing, so input is taken from the first cycle after reset.
module cartesian_to_radar_polar (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  crp_in_if.sink                     in_i,
  crp_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [crp_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // Configuration: one register, min_range, in the low half of word 0. Writes to
  // any other word are dropped and read back as zero.
  logic [15:0] min_range_q, min_range_d;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == crp_pkg::REG_MIN_RANGE);

  always_comb begin
    min_range_d = cfg_wr ? pwdata[15:0] : min_range_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q <= 16'd1;
    end else begin
      min_range_q <= min_range_d;
    end
  end

  assign prdata = (paddr[2] == crp_pkg::REG_MIN_RANGE) ? {16'b0, min_range_q} : '0;

  // The front end wraps the heading and sets up the vectoring rotation, then
  // writes the beat into a short queue. The back end pulls from the queue head
  // whenever its pipeline can advance, so a stalled result only backs up the
  // queue and the front keeps accepting until the queue fills.
  crp_pkg::q_entry_t entry;
  crp_pkg::q_entry_t head;
  logic push, pop, full, empty;

  crp_front u_front (
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  crp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  // The back end stalls as a whole while its output register holds an untaken
  // result; the dot product and the range meet at the divider, and the near
  // origin test overrides all three results at the output.
  crp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_range_i (min_range_q),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

/* design/crp_checker.sv */
// Port-level assertions of the radar measurement block, bound to the top level.
// Depends on crp_pkg and on cartesian_to_radar_polar for the bind.
module crp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic        [31:0] range_i,
  input logic signed [30:0] bearing_i,
  input logic signed [31:0] range_rate_i,
  input logic               at_origin_i
);

  a_origin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && at_origin_i |-> range_i == '0 && bearing_i == '0 && range_rate_i == '0)
    else $error("origin result carries nonzero fields");

  a_range_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !at_origin_i |-> range_i != '0)
    else $error("zero range without origin flag");

  a_bearing_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ($signed(bearing_i) <= crp_pkg::ANG_MAX) &&
                    ($signed(bearing_i) >= -crp_pkg::ANG_MAX))
    else $error("bearing outside of plus or minus pi");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(range_i) &&
                                    $stable(range_rate_i) && $stable(bearing_i))
    else $error("stalled result changed");

endmodule

bind cartesian_to_radar_polar crp_checker u_crp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .range_i      (out_o.range),
  .bearing_i    (out_o.bearing),
  .range_rate_i (out_o.range_rate),
  .at_origin_i  (out_o.at_origin)
);

/* dv/testbench.sv */
// Self-checking testbench of cartesian_to_radar_polar: directed rows, then random beats.
// Depends on crp_pkg, crp_if and the block's RTL. It predicts every result itself but for typed-in at-origin rows.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LIMIT_CYCLES   = 400000;
  localparam int          DRAIN_CYCLES   = 120;
  localparam int          RANDOM_PER_SET = 500;
  localparam logic [2:0]  MIN_RANGE_ADDR = 3'(4 * int'(crp_pkg::REG_MIN_RANGE));

  // Angle constants in Q3.28 and the CORDIC gain in Q2.30.
  localparam longint A_PI      = 64'sd843314857;
  localparam longint A_HALF_PI = 64'sd421657428;
  localparam longint A_TWO_PI  = 64'sd1686629713;
  localparam longint GAIN_Q30  = 64'sd652032874;
  localparam longint UNIT_Q30  = 64'sd1073741824;
  localparam longint ATAN_LEAD [10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                                        8385879, 4193963, 2097109, 1048571, 524287};

  typedef struct packed {
    logic        [31:0] range;
    logic signed [30:0] bearing;
    logic signed [31:0] range_rate;
    logic               at_origin;
  } radar_meas_t;

  typedef struct {
    int pos_x;
    int pos_y;
    int speed;
    int heading;
    bit at_origin_row;
  } track_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [crp_pkg::CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  crp_in_if  track_ch ();
  crp_out_if meas_ch ();

  cartesian_to_radar_polar u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (track_ch),
    .out_o   (meas_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Our copy of the min_range register.
  logic [15:0] min_range_q;
  radar_meas_t pending_meas[$];
  int          error_count;
  int          cycle_count;
  bit          steady_send;
  bit          steady_recv;

  // Directed rows. Only the at-origin rows carry a typed-in result (all zero with the
  // flag set); every other row goes through the predictor.
  track_row_t directed_rows[] = '{
    '{0, 0, 0, 0, 1'b1},
    '{0, 0, 32'sh7fffffff, 32'sh80000000, 1'b1},
    '{1, 1, 32'sh7fffffff, 210828714, 1'b0},
    '{1, 1, 32'sh80000000, 210828714, 1'b0},
    '{-1, -1, 32'sh7fffffff, -632486143, 1'b0},
    '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0},
    '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0},
    '{32'sh80000000, 0, 65536, 0, 1'b0},
    '{0, 32'sh80000000, 65536, 0, 1'b0},
    '{32'sh7fffffff, 0, 32'sh80000000, 32'sh7fffffff, 1'b0},
    '{0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b0},
    '{-65536, 0, 65536, 843314857, 1'b0},
    '{-65536, -1, 65536, -843314857, 1'b0},
    '{-65536, 1, 65536, 421657428, 1'b0},
    '{65536, 0, 65536, -421657428, 1'b0},
    '{0, 65536, 65536, 421657429, 1'b0},
    '{0, -65536, -65536, -421657429, 1'b0},
    '{100000, -200000, 300000, 2000000000, 1'b0},
    '{-300000, 200000, -300000, -2000000000, 1'b0},
    '{1, 0, 1, 0, 1'b0},
    '{0, -1, -1, 1, 1'b0}
  };

  // Range, bearing and range rate of one tracked point under the current min_range.
  function automatic radar_meas_t radar_measure(int px_i, int py_i, int spd_i, int hd_i);
    radar_meas_t m;
    longint px, py, spd, h, cx, cy, t, z, vx, vy, dot, rr, step_ang;
    longint ax, ay;
    logic [63:0] rem, root, bitv;
    bit flip;
    px  = px_i;
    py  = py_i;
    spd = spd_i;
    h   = hd_i;
    m   = '0;
    // Integer square root of px^2 + py^2, digit by digit.
    rem  = 64'(px * px) + 64'(py * py);
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (root == 0 || root < 64'(min_range_q)) begin
      m.at_origin = 1'b1;
      return m;
    end
    // Rotation-mode CORDIC for cos and sin of the heading.
    while (h > A_PI) h -= A_TWO_PI;
    while (h < -A_PI) h += A_TWO_PI;
    flip = 1'b0;
    if (h > A_HALF_PI) begin
      h -= A_PI;
      flip = 1'b1;
    end else if (h < -A_HALF_PI) begin
      h += A_PI;
      flip = 1'b1;
    end
    cx = GAIN_Q30;
    cy = 0;
    for (int i = 0; i < crp_pkg::CORDIC_STEPS; i++) begin
      step_ang = (i < 10) ? ATAN_LEAD[i] : ((i <= 28) ? (64'sd1 <<< (28 - i)) : 0);
      if (h >= 0) begin
        t  = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        h -= step_ang;
      end else begin
        t  = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        h += step_ang;
      end
      cx = t;
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    cx = (cx > UNIT_Q30) ? UNIT_Q30 : ((cx < -UNIT_Q30) ? -UNIT_Q30 : cx);
    cy = (cy > UNIT_Q30) ? UNIT_Q30 : ((cy < -UNIT_Q30) ? -UNIT_Q30 : cy);
    vx = (spd * cx) >>> 30;
    vy = (spd * cy) >>> 30;
    vx = (vx > 64'sd2147483647) ? 64'sd2147483647 : ((vx < -64'sd2147483647) ? -64'sd2147483647 : vx);
    vy = (vy > 64'sd2147483647) ? 64'sd2147483647 : ((vy < -64'sd2147483647) ? -64'sd2147483647 : vy);
    dot = px * vx + py * vy;
    rr  = dot / longint'(root);
    rr  = (rr > 64'sd2147483647) ? 64'sd2147483647 : ((rr < -64'sd2147483648) ? -64'sd2147483648 : rr);
    // Vectoring-mode CORDIC for the bearing, left half plane turned by a quarter first.
    ax = px * UNIT_Q30;
    ay = py * UNIT_Q30;
    z  = 0;
    if (ax < 0) begin
      if (ay >= 0) begin
        t = ay; ay = -ax; ax = t; z = A_HALF_PI;
      end else begin
        t = -ay; ay = ax; ax = t; z = -A_HALF_PI;
      end
    end
    for (int i = 0; i < crp_pkg::CORDIC_STEPS; i++) begin
      step_ang = (i < 10) ? ATAN_LEAD[i] : ((i <= 28) ? (64'sd1 <<< (28 - i)) : 0);
      if (ay > 0) begin
        t  = ax + (ay >>> i);
        ay = ay - (ax >>> i);
        z += step_ang;
      end else begin
        t  = ax - (ay >>> i);
        ay = ay + (ax >>> i);
        z -= step_ang;
      end
      ax = t;
    end
    z = (z > A_PI) ? A_PI : ((z < -A_PI) ? -A_PI : z);
    m.range      = root[31:0];
    m.bearing    = z[30:0];
    m.range_rate = rr[31:0];
    return m;
  endfunction

  // Clock: 12 ns period.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Watchdog: the slowest correct run is far below this.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The result side stalls at random, about 11 percent of the time, unless a steady stretch is on.
  always @(negedge clk_i) begin
    meas_ch.ready <= steady_recv || ($urandom_range(99) >= 11);
  end

  // Each result beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    radar_meas_t want;
    if (rst_ni && meas_ch.valid && meas_ch.ready) begin
      if (pending_meas.size() == 0) begin
        $display("%0t: result beat with no prediction waiting: range %h", $realtime,
                 meas_ch.range);
        error_count++;
      end else begin
        want = pending_meas.pop_front();
        if (meas_ch.range !== want.range) begin
          $display("%0t: range expected %h actual %h", $realtime, want.range, meas_ch.range);
          error_count++;
        end
        if (meas_ch.bearing !== want.bearing) begin
          $display("%0t: bearing expected %h actual %h", $realtime, want.bearing,
                   meas_ch.bearing);
          error_count++;
        end
        if (meas_ch.range_rate !== want.range_rate) begin
          $display("%0t: range_rate expected %h actual %h", $realtime, want.range_rate,
                   meas_ch.range_rate);
          error_count++;
        end
        if (meas_ch.at_origin !== want.at_origin) begin
          $display("%0t: at_origin expected %b actual %b", $realtime, want.at_origin,
                   meas_ch.at_origin);
          error_count++;
        end
      end
    end
  end

  // Sends one track beat, called at a falling edge and returning at one. When the
  // expectation is typed in, it is used instead of the predictor.
  task automatic send_track(int px, int py, int spd, int hd, bit use_typed,
                            radar_meas_t typed_meas);
    while (!steady_send && $urandom_range(99) < 11) begin
      track_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    track_ch.valid   <= 1'b1;
    track_ch.pos_x   <= px;
    track_ch.pos_y   <= py;
    track_ch.speed   <= spd;
    track_ch.heading <= hd;
    @(posedge clk_i);
    while (!track_ch.ready) @(posedge clk_i);
    pending_meas.push_back(use_typed ? typed_meas : radar_measure(px, py, spd, hd));
    @(negedge clk_i);
  endtask

  // APB write of min_range: setup cycle, then access cycle; the block takes it at the
  // rising edge of the access cycle since pready is always high.
  task automatic write_min_range(logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MIN_RANGE_ADDR;
    pwdata  <= {16'h0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    min_range_q = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Waits at a falling edge until every prediction has been met, then lets the pipe empty.
  task automatic drain_pipe();
    track_ch.valid <= 1'b0;
    while (pending_meas.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    radar_meas_t origin_meas;
    logic [15:0] range_settings[4];
    int px, py, spd, hd, kind;
    origin_meas = '0;
    origin_meas.at_origin = 1'b1;
    range_settings = '{16'd0, 16'd65535, 16'($urandom), 16'd1000};
    error_count = 0;
    cycle_count = 0;
    steady_send = 1'b0;
    steady_recv = 1'b0;
    min_range_q = 16'd1;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    track_ch.valid = 1'b0;
    track_ch.pos_x = '0;
    track_ch.pos_y = '0;
    track_ch.speed = '0;
    track_ch.heading = '0;
    meas_ch.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part under the reset value of min_range.
    foreach (directed_rows[r]) begin
      send_track(directed_rows[r].pos_x, directed_rows[r].pos_y, directed_rows[r].speed,
                 directed_rows[r].heading, directed_rows[r].at_origin_row, origin_meas);
    end
    drain_pipe();

    // Random part, one set of beats per min_range setting. The second set runs with no
    // idling on either side, so the pipeline sees back-to-back beats.
    foreach (range_settings[s]) begin
      write_min_range(range_settings[s]);
      steady_send = (s == 1);
      steady_recv = (s == 1);
      for (int n = 0; n < RANDOM_PER_SET; n++) begin
        kind = $urandom_range(99);
        if (kind < 20) begin
          // Close to the origin, around the at-origin threshold.
          px = int'($urandom_range(80000)) - 40000;
          py = int'($urandom_range(80000)) - 40000;
        end else if (kind < 75) begin
          // Typical positions of random magnitude.
          px = int'($urandom) >>> $urandom_range(0, 30);
          py = int'($urandom) >>> $urandom_range(0, 30);
        end else begin
          px = int'($urandom);
          py = int'($urandom);
        end
        spd = ($urandom_range(3) == 0) ? int'($urandom) : (int'($urandom) >>> $urandom_range(0, 24));
        hd  = int'($urandom);
        send_track(px, py, spd, hd, 1'b0, origin_meas);
      end
      drain_pipe();
    end
    steady_send = 1'b0;
    steady_recv = 1'b0;

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
